// ===== hdl/ari8_pkg.sv =====
// Shared types and constants for the active-row int8 affine block.
// No dependencies; imported by ari8_lanes, the top level and the testbench.
`timescale 1ns / 1ps

package ari8_pkg;

    // Operation codes carried on the op field.
    localparam logic [1:0] OP_LOAD_SAMPLE = 2'd0;
    localparam logic [1:0] OP_LOAD_WEIGHT = 2'd1;
    localparam logic [1:0] OP_LOAD_BIAS   = 2'd2;
    localparam logic [1:0] OP_COMPUTE     = 2'd3;

    // Configuration register indexes.
    localparam logic REG_ELEMENT_COUNT = 1'b0;
    localparam logic REG_VECTOR_COUNT  = 1'b1;

    // Fixed datapath widths.
    localparam int OUT_LANES = 8;
    localparam int SAMPLE_W  = 16;
    localparam int WEIGHT_W  = 8;
    localparam int PROD_W    = SAMPLE_W + WEIGHT_W;
    localparam int ACC_W     = 32;
    localparam int SCALE_W   = 8;

    // Control from the sequencer to the lane datapath.
    typedef struct packed {
        logic acc_clear;  // start of a compute: zero the accumulators
        logic mul_en;     // memory read data is valid this cycle
        logic acc_en;     // registered products are valid this cycle
        logic scale_en;   // apply the row multiplier to the sums
    } lane_ctrl_t;

endpackage

// ===== hdl/ari8_ram.sv =====
// Generic single-write, single-read synchronous RAM with a registered read.
// No dependencies.
`timescale 1ns / 1ps

module ari8_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== hdl/ari8_lanes.sv =====
// Per-vector multiply-accumulate lanes, row scaling and bias addition.
// Depends on ari8_pkg for widths and the lane control struct.
`timescale 1ns / 1ps

module ari8_lanes
    import ari8_pkg::*;
#(
    parameter int MAX_VECTORS = 8
) (
    input  logic                       clk,
    input  lane_ctrl_t                 ctrl,
    input  logic signed [SAMPLE_W-1:0] sample_rdata [MAX_VECTORS],
    input  logic signed [WEIGHT_W-1:0] weight_rdata,
    input  logic [ACC_W-1:0]           bias,
    input  logic [SCALE_W-1:0]         scale,
    input  logic [3:0]                 n_vec,
    input  logic                       row_ok,
    output logic [ACC_W-1:0]           lane_result [OUT_LANES]
);

    genvar v;
    generate
        for (v = 0; v < OUT_LANES; v++)
        begin : g_lane
            if (v < MAX_VECTORS)
            begin : g_used
                logic signed [PROD_W-1:0] prod_reg;
                logic [ACC_W-1:0]         acc_reg;
                logic [ACC_W-1:0]         scaled_reg;
                logic                     lane_on;

                always_ff @(posedge clk)
                begin
                    if (ctrl.mul_en)
                    begin
                        prod_reg <= sample_rdata[v] * weight_rdata;
                    end
                    if (ctrl.acc_clear)
                    begin
                        acc_reg <= '0;
                    end
                    else if (ctrl.acc_en)
                    begin
                        acc_reg <= acc_reg + {{(ACC_W-PROD_W){prod_reg[PROD_W-1]}}, prod_reg};
                    end
                    if (ctrl.scale_en)
                    begin
                        // Only the low 32 bits of the product are kept.
                        scaled_reg <= acc_reg * {{(ACC_W-SCALE_W){1'b0}}, scale};
                    end
                end

                assign lane_on        = row_ok && (4'(v) < n_vec);
                assign lane_result[v] = lane_on ? bias + scaled_reg : '0;
            end
            else
            begin : g_absent
                assign lane_result[v] = '0;
            end
        end
    endgenerate

endmodule

// ===== hdl/active_row_int8_affine.sv =====
// Top level of the active-row int8 affine block: sequencer, stores and ports.
// Depends on ari8_pkg, ari8_ram and ari8_lanes.
`timescale 1ns / 1ps

// Load transfers (samples, weights, bias with multiplier) are written to the
// on-chip memories in the cycle they are accepted, so one load is taken per
// cycle while no compute is under way. A compute transfer names a row and walks
// the row's weights one element per cycle from the single read port of the
// weight memory, all vectors in parallel. It occupies the block while it reads
// the elements (as many as the element count, capped at MAX_ELEMENTS), drains
// the read and multiply pipeline, lets the sums settle, scales them and, once
// the output register is free, registers the result. With an element count of
// zero there is nothing to read or drain. A row outside the store goes straight
// to the result step with zero lanes. While a compute is under way no further
// transfer is taken; the result waits in an output register so loads and the
// next compute may be accepted before it is collected. Stores have no reset and
// must be written before they are read. Configuration writes are taken at any
// time but must only be made while the block is idle.
module active_row_int8_affine
    import ari8_pkg::*;
#(
    parameter int MAX_ELEMENTS = 256,
    parameter int MAX_ROWS     = 256,
    parameter int MAX_VECTORS  = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    // Input channel.
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  op,
    input  logic [7:0]  column,
    input  logic [2:0]  vector,
    input  logic signed [15:0] sample,
    input  logic [7:0]  row,
    input  logic signed [7:0]  weight,
    input  logic signed [31:0] bias,
    input  logic [7:0]  multiplier,
    // Result channel.
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  result_row,
    output logic signed [31:0] out_0,
    output logic signed [31:0] out_1,
    output logic signed [31:0] out_2,
    output logic signed [31:0] out_3,
    output logic signed [31:0] out_4,
    output logic signed [31:0] out_5,
    output logic signed [31:0] out_6,
    output logic signed [31:0] out_7,
    // Configuration write port.
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [8:0]  cfg_data
);

    localparam int EAW = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
    localparam int KW  = $clog2(MAX_ELEMENTS + 1);
    localparam int RAW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int WDEPTH = MAX_ROWS * MAX_ELEMENTS;
    localparam int WAW = (WDEPTH > 1) ? $clog2(WDEPTH) : 1;
    localparam int BW  = ACC_W + SCALE_W;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_RUN    = 3'd1;
    localparam logic [2:0] ST_DRAIN  = 3'd2;
    localparam logic [2:0] ST_SCALE  = 3'd3;
    localparam logic [2:0] ST_FINISH = 3'd4;

    logic [2:0]    state_reg, state_next;
    logic [KW-1:0] k_reg, k_next;
    logic          rd_valid_reg, prod_valid_reg;
    logic          row_ok_reg, row_ok_next;
    logic [7:0]    row_reg;
    logic [8:0]    element_count_reg;
    logic [3:0]    vector_count_reg;
    logic          out_valid_reg, out_valid_next;
    logic [7:0]    result_row_reg;
    logic [ACC_W-1:0] out_reg [OUT_LANES];

    logic          accept, is_compute, load_out;
    logic          col_ok, row_in_ok, vec_ok;
    logic          issue;
    logic [KW-1:0] n_el;
    logic [3:0]    n_vec;
    logic [WAW-1:0] w_waddr, w_raddr;
    logic [BW-1:0] bias_rdata;
    logic [WEIGHT_W-1:0] weight_rdata;
    logic signed [SAMPLE_W-1:0] sample_rdata [MAX_VECTORS];
    logic [ACC_W-1:0] lane_result [OUT_LANES];
    lane_ctrl_t    ctrl;

    assign in_ready   = (state_reg == ST_IDLE);
    assign accept     = in_valid && in_ready;
    assign is_compute = (op == OP_COMPUTE);

    assign col_ok    = 32'(column) < 32'(MAX_ELEMENTS);
    assign row_in_ok = 32'(row) < 32'(MAX_ROWS);
    assign vec_ok    = 32'(vector) < 32'(MAX_VECTORS);

    // Element and vector counts are capped at what the stores hold.
    assign n_el  = (32'(element_count_reg) > 32'(MAX_ELEMENTS)) ?
                   KW'(MAX_ELEMENTS) : KW'(element_count_reg);
    assign n_vec = (32'(vector_count_reg) > 32'(MAX_VECTORS)) ?
                   4'(MAX_VECTORS) : vector_count_reg;

    // Weight rows are laid out one after another in the weight memory.
    assign w_waddr = WAW'(row) * WAW'(MAX_ELEMENTS) + WAW'(column);
    assign w_raddr = WAW'(row_reg) * WAW'(MAX_ELEMENTS) + WAW'(k_reg);

    assign issue = (state_reg == ST_RUN);

    // Stores are only written while idle and only read while a compute runs,
    // so a read and a write of the same entry never overlap.
    genvar gv;
    generate
        for (gv = 0; gv < MAX_VECTORS; gv++)
        begin : g_sample_mem
            logic [SAMPLE_W-1:0] rd;

            ari8_ram #(
                .WIDTH (SAMPLE_W),
                .DEPTH (MAX_ELEMENTS)
            ) u_sample_ram (
                .clk   (clk),
                .we    (accept && (op == OP_LOAD_SAMPLE) && col_ok && vec_ok &&
                        (32'(vector) == gv)),
                .waddr (EAW'(column)),
                .wdata (sample),
                .re    (issue),
                .raddr (EAW'(k_reg)),
                .rdata (rd)
            );

            assign sample_rdata[gv] = $signed(rd);
        end
    endgenerate

    ari8_ram #(
        .WIDTH (WEIGHT_W),
        .DEPTH (WDEPTH)
    ) u_weight_ram (
        .clk   (clk),
        .we    (accept && (op == OP_LOAD_WEIGHT) && row_in_ok && col_ok),
        .waddr (w_waddr),
        .wdata (weight),
        .re    (issue),
        .raddr (w_raddr),
        .rdata (weight_rdata)
    );

    // Bias and multiplier share one entry per row; the read is made when the
    // compute is accepted and the data then holds until the next compute.
    ari8_ram #(
        .WIDTH (BW),
        .DEPTH (MAX_ROWS)
    ) u_bias_ram (
        .clk   (clk),
        .we    (accept && (op == OP_LOAD_BIAS) && row_in_ok),
        .waddr (RAW'(row)),
        .wdata ({multiplier, bias}),
        .re    (accept && is_compute && row_in_ok),
        .raddr (RAW'(row)),
        .rdata (bias_rdata)
    );

    assign ctrl.acc_clear = accept && is_compute;
    assign ctrl.mul_en    = rd_valid_reg;
    assign ctrl.acc_en    = prod_valid_reg;
    assign ctrl.scale_en  = (state_reg == ST_SCALE);

    ari8_lanes #(
        .MAX_VECTORS (MAX_VECTORS)
    ) u_lanes (
        .clk          (clk),
        .ctrl         (ctrl),
        .sample_rdata (sample_rdata),
        .weight_rdata ($signed(weight_rdata)),
        .bias         (bias_rdata[ACC_W-1:0]),
        .scale        (bias_rdata[BW-1:ACC_W]),
        .n_vec        (n_vec),
        .row_ok       (row_ok_reg),
        .lane_result  (lane_result)
    );

    // The finished result is registered once the output register is free.
    assign load_out = (state_reg == ST_FINISH) && (!out_valid_reg || out_ready);

    always_comb
    begin
        state_next     = state_reg;
        k_next         = k_reg;
        row_ok_next    = row_ok_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && is_compute)
                begin
                    k_next      = '0;
                    row_ok_next = row_in_ok;
                    if (!row_in_ok)
                    begin
                        state_next = ST_FINISH;
                    end
                    else if (n_el == '0)
                    begin
                        state_next = ST_DRAIN;
                    end
                    else
                    begin
                        state_next = ST_RUN;
                    end
                end
            end
            ST_RUN:
            begin
                k_next = KW'(k_reg + KW'(1));
                if (k_next == n_el)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!rd_valid_reg && !prod_valid_reg)
                begin
                    state_next = ST_SCALE;
                end
            end
            ST_SCALE:
            begin
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (load_out)
                begin
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            k_reg             <= '0;
            rd_valid_reg      <= 1'b0;
            prod_valid_reg    <= 1'b0;
            row_ok_reg        <= 1'b0;
            out_valid_reg     <= 1'b0;
            element_count_reg <= 9'd1;
            vector_count_reg  <= 4'd1;
        end
        else
        begin
            state_reg      <= state_next;
            k_reg          <= k_next;
            rd_valid_reg   <= issue;
            prod_valid_reg <= rd_valid_reg;
            row_ok_reg     <= row_ok_next;
            out_valid_reg  <= out_valid_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_ELEMENT_COUNT: element_count_reg <= cfg_data;
                    REG_VECTOR_COUNT:  vector_count_reg  <= cfg_data[3:0];
                    default:           element_count_reg <= element_count_reg;
                endcase
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (accept && is_compute)
        begin
            row_reg <= row;
        end
        if (load_out)
        begin
            result_row_reg <= row_reg;
            for (int i = 0; i < OUT_LANES; i++)
            begin
                out_reg[i] <= lane_result[i];
            end
        end
    end

    assign out_valid  = out_valid_reg;
    assign result_row = result_row_reg;
    assign out_0 = $signed(out_reg[0]);
    assign out_1 = $signed(out_reg[1]);
    assign out_2 = $signed(out_reg[2]);
    assign out_3 = $signed(out_reg[3]);
    assign out_4 = $signed(out_reg[4]);
    assign out_5 = $signed(out_reg[5]);
    assign out_6 = $signed(out_reg[6]);
    assign out_7 = $signed(out_reg[7]);

endmodule

// ===== sim/active_row_int8_affine_tb.sv =====
// Self-checking testbench for the active-row int8 affine block.
// Depends on ari8_pkg and the active_row_int8_affine RTL with its ari8_ram and ari8_lanes.
`timescale 1ns / 1ps

module active_row_int8_affine_tb;
    import ari8_pkg::*;

    // Store geometry as built here; the block is instanced with the same values.
    localparam int MAX_ELEMENTS = 256;
    localparam int MAX_ROWS     = 256;
    localparam int MAX_VECTORS  = 8;

    // The stimulus stops once roughly this many input transfers have been made.
    localparam int TARGET_ITEMS = 1900;

    // Above this element count computes use a single row, so that its weights
    // and the samples behind it are loaded only once.
    localparam int         SMALL_ELEMENTS = 16;
    localparam logic [7:0] WIDE_ROW       = 8'd255;

    // Loads give no result, so a few cycles are allowed after the last result
    // before a register is written. At the end a full compute is waited out.
    localparam int SETTLE_CYCLES = 8;
    localparam int TAIL_CYCLES   = 300;

    // One input transfer, field for field as on the ports.
    typedef struct packed {
        logic [1:0]  op;
        logic [7:0]  column;
        logic [2:0]  vector;
        logic [15:0] sample;
        logic [7:0]  row;
        logic [7:0]  weight;
        logic [31:0] bias;
        logic [7:0]  multiplier;
    } affine_item_t;

    // One result transfer: the row and its eight lanes, lane 0 lowest.
    typedef struct packed {
        logic [7:0]                 row;
        logic [OUT_LANES-1:0][31:0] lanes;
    } row_result_t;

    // Ways in which the result side holds off.
    typedef enum int {
        STALL_NONE,
        STALL_COIN,
        STALL_SPARSE,
        STALL_LONG
    } stall_mode_t;

    // The scoreboard keeps its own copy of the stores and the two registers.
    // Every accepted compute pushes the row sums it must produce; every
    // collected result is compared with the oldest of them.
    class row_affine_scoreboard;
        logic [15:0] sample_mem [0:MAX_ELEMENTS*MAX_VECTORS-1];
        logic [7:0]  weight_mem [0:MAX_ROWS*MAX_ELEMENTS-1];
        logic [31:0] bias_mem   [0:MAX_ROWS-1];
        logic [7:0]  scale_mem  [0:MAX_ROWS-1];
        logic [8:0]  element_count;
        logic [3:0]  vector_count;
        row_result_t expected_rows [$];
        int unsigned mismatches;
        int unsigned results_checked;

        function new();
            element_count   = 9'd1;
            vector_count    = 4'd1;
            mismatches      = 0;
            results_checked = 0;
        endfunction

        function void write_register(logic index, logic [8:0] data);
            if (index == REG_ELEMENT_COUNT)
                element_count = data;
            else
                vector_count = data[3:0];
        endfunction

        function int unsigned pending();
            return expected_rows.size();
        endfunction

        function void note_transfer(affine_item_t it);
            row_result_t res;
            bit [31:0]   acc [OUT_LANES];
            int unsigned n_el;
            int unsigned n_vec;
            int          s;
            int          w;
            logic [7:0]  col;
            case (it.op)
                OP_LOAD_SAMPLE: sample_mem[{it.column, it.vector}] = it.sample;
                OP_LOAD_WEIGHT: weight_mem[{it.row, it.column}] = it.weight;
                OP_LOAD_BIAS:
                begin
                    bias_mem[it.row]  = it.bias;
                    scale_mem[it.row] = it.multiplier;
                end
                OP_COMPUTE:
                begin
                    // Counts beyond the store saturate.
                    n_el  = (element_count > MAX_ELEMENTS) ? MAX_ELEMENTS : element_count;
                    n_vec = (vector_count > MAX_VECTORS) ? MAX_VECTORS : vector_count;
                    res     = '0;
                    res.row = it.row;
                    for (int v = 0; v < OUT_LANES; v++)
                        acc[v] = '0;
                    // Products are signed; the sums wrap at 32 bits.
                    for (int k = 0; k < n_el; k++)
                    begin
                        col = k[7:0];
                        w   = $signed(weight_mem[{it.row, col}]);
                        for (int v = 0; v < n_vec; v++)
                        begin
                            s      = $signed(sample_mem[{col, v[2:0]}]);
                            acc[v] = acc[v] + s * w;
                        end
                    end
                    // Unused lanes stay zero.
                    for (int v = 0; v < n_vec; v++)
                        res.lanes[v] = bias_mem[it.row] + {24'd0, scale_mem[it.row]} * acc[v];
                    expected_rows.push_back(res);
                end
                default:
                begin
                end
            endcase
        endfunction

        task report_mismatch(string what);
            mismatches++;
            $display("[%0t] mismatch: %s", $time, what);
        endtask

        task check_result(row_result_t got);
            row_result_t want;
            string       diffs;
            if (expected_rows.size() == 0)
            begin
                report_mismatch($sformatf("result for row %0d with none expected", got.row));
                return;
            end
            want = expected_rows.pop_front();
            results_checked++;
            diffs = "";
            if (got.row !== want.row)
                diffs = {diffs, $sformatf(" result_row %0d/%0d", got.row, want.row)};
            for (int v = 0; v < OUT_LANES; v++)
                if (got.lanes[v] !== want.lanes[v])
                    diffs = {diffs, $sformatf(" out_%0d %h/%h", v, got.lanes[v], want.lanes[v])};
            if (diffs != "")
                report_mismatch($sformatf("row %0d got/expected:%s", want.row, diffs));
        endtask
    endclass

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  op;
    logic [7:0]  column;
    logic [2:0]  vector;
    logic signed [15:0] sample;
    logic [7:0]  row;
    logic signed [7:0]  weight;
    logic signed [31:0] bias;
    logic [7:0]  multiplier;
    logic        out_valid;
    logic        out_ready;
    logic [7:0]  result_row;
    logic signed [31:0] out_0;
    logic signed [31:0] out_1;
    logic signed [31:0] out_2;
    logic signed [31:0] out_3;
    logic signed [31:0] out_4;
    logic signed [31:0] out_5;
    logic signed [31:0] out_6;
    logic signed [31:0] out_7;
    logic        cfg_we;
    logic        cfg_index;
    logic [8:0]  cfg_data;

    active_row_int8_affine #(
        .MAX_ELEMENTS(MAX_ELEMENTS),
        .MAX_ROWS    (MAX_ROWS),
        .MAX_VECTORS (MAX_VECTORS)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .op        (op),
        .column    (column),
        .vector    (vector),
        .sample    (sample),
        .row       (row),
        .weight    (weight),
        .bias      (bias),
        .multiplier(multiplier),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .result_row(result_row),
        .out_0     (out_0),
        .out_1     (out_1),
        .out_2     (out_2),
        .out_3     (out_3),
        .out_4     (out_4),
        .out_5     (out_5),
        .out_6     (out_6),
        .out_7     (out_7),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    row_affine_scoreboard affine_board = new();

    // The stores have no reset, so the stimulus keeps track of which entries
    // have been written and loads any missing ones before a compute reads them.
    bit sample_written [0:MAX_ELEMENTS*MAX_VECTORS-1];
    bit weight_written [0:MAX_ROWS*MAX_ELEMENTS-1];
    bit bias_written   [0:MAX_ROWS-1];

    // The register values the stimulus has programmed, for choosing indexes.
    logic [8:0]  stim_elements = 9'd1;
    logic [3:0]  stim_vectors  = 4'd1;
    int unsigned burst_left    = 0;
    int unsigned items_sent    = 0;
    int unsigned settings_made = 0;
    row_result_t collected;

    // 12 ns clock.
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Values near the edges of a field turn up often; the rest are uniform.
    function automatic logic [31:0] rand_field(int unsigned bits);
        logic [31:0] mask;
        logic [31:0] v;
        mask = (bits >= 32) ? 32'hFFFF_FFFF : ((32'd1 << bits) - 32'd1);
        case ($urandom_range(0, 9))
            0:       v = 32'd1 << (bits - 1);
            1:       v = mask >> 1;
            2:       v = mask;
            3:       v = '0;
            default: v = $urandom();
        endcase
        return v & mask;
    endfunction

    // Fields an operation does not use still carry random values.
    function automatic affine_item_t scrambled_item();
        affine_item_t it;
        it.op         = OP_LOAD_SAMPLE;
        it.column     = 8'($urandom());
        it.vector     = 3'($urandom());
        it.sample     = 16'($urandom());
        it.row        = 8'($urandom());
        it.weight     = 8'($urandom());
        it.bias       = $urandom();
        it.multiplier = 8'($urandom());
        return it;
    endfunction

    function automatic int unsigned active_elements();
        return (stim_elements > MAX_ELEMENTS) ? MAX_ELEMENTS : stim_elements;
    endfunction

    function automatic int unsigned active_vectors();
        return (stim_vectors > MAX_VECTORS) ? MAX_VECTORS : stim_vectors;
    endfunction

    // Small phases spread computes over many rows with a bias towards a few
    // that recur; wide phases stick to one row.
    function automatic logic [7:0] pick_row();
        if (active_elements() > SMALL_ELEMENTS)
            return WIDE_ROW;
        case ($urandom_range(0, 11))
            0:       return 8'd0;
            1:       return 8'd255;
            2:       return 8'd1;
            3:       return 8'd128;
            4:       return 8'd85;
            5:       return 8'd170;
            6:       return 8'd127;
            7:       return 8'd64;
            default: return 8'($urandom());
        endcase
    endfunction

    // Input side. Every call is entered at a falling edge and returns at the
    // falling edge after its transfer, with valid still high; the caller then
    // presents the next item or lowers valid in the same step. Items go out in
    // bursts of random length, most of them preceded by a random gap.
    task automatic drive_item(input affine_item_t it);
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            if ($urandom_range(0, 3) != 0)
            begin
                in_valid = 1'b0;
                repeat ($urandom_range(1, 8)) @(negedge clk);
            end
        end
        burst_left--;
        op         = it.op;
        column     = it.column;
        vector     = it.vector;
        sample     = it.sample;
        row        = it.row;
        weight     = it.weight;
        bias       = it.bias;
        multiplier = it.multiplier;
        in_valid   = 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        affine_board.note_transfer(it);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic load_sample(input logic [7:0] col, input logic [2:0] vec,
                               input logic [15:0] value);
        affine_item_t it;
        it        = scrambled_item();
        it.op     = OP_LOAD_SAMPLE;
        it.column = col;
        it.vector = vec;
        it.sample = value;
        sample_written[{col, vec}] = 1'b1;
        drive_item(it);
    endtask

    task automatic load_weight(input logic [7:0] r, input logic [7:0] col,
                               input logic [7:0] value);
        affine_item_t it;
        it        = scrambled_item();
        it.op     = OP_LOAD_WEIGHT;
        it.row    = r;
        it.column = col;
        it.weight = value;
        weight_written[{r, col}] = 1'b1;
        drive_item(it);
    endtask

    task automatic load_bias(input logic [7:0] r, input logic [31:0] value,
                             input logic [7:0] scale);
        affine_item_t it;
        it            = scrambled_item();
        it.op         = OP_LOAD_BIAS;
        it.row        = r;
        it.bias       = value;
        it.multiplier = scale;
        bias_written[r] = 1'b1;
        drive_item(it);
    endtask

    // A compute is preceded by loads of whatever it will read that has not
    // been written yet, so no unwritten store entry is ever read.
    task automatic compute_row(input logic [7:0] r);
        affine_item_t it;
        logic [7:0]   col;
        for (int k = 0; k < active_elements(); k++)
        begin
            col = k[7:0];
            if (!weight_written[{r, col}])
                load_weight(r, col, 8'(rand_field(8)));
            for (int v = 0; v < active_vectors(); v++)
                if (!sample_written[{col, v[2:0]}])
                    load_sample(col, v[2:0], 16'(rand_field(16)));
        end
        if (!bias_written[r])
            load_bias(r, rand_field(32), 8'(rand_field(8)));
        it     = scrambled_item();
        it.op  = OP_COMPUTE;
        it.row = r;
        drive_item(it);
    endtask

    // Mostly computes and loads that land where the current setting reads,
    // with some loads scattered anywhere in the stores.
    task automatic random_transfer();
        int unsigned n_el;
        int unsigned n_vec;
        int unsigned sel;
        logic [7:0]  col;
        logic [2:0]  vec;
        n_el  = active_elements();
        n_vec = active_vectors();
        col   = (n_el == 0) ? 8'($urandom()) : 8'($urandom_range(0, n_el - 1));
        vec   = (n_vec == 0) ? 3'($urandom()) : 3'($urandom_range(0, n_vec - 1));
        sel   = $urandom_range(0, 99);
        if (sel < 30)
            compute_row(pick_row());
        else if (sel < 50)
            load_weight(pick_row(), col, 8'(rand_field(8)));
        else if (sel < 70)
            load_sample(col, vec, 16'(rand_field(16)));
        else if (sel < 80)
            load_bias(pick_row(), rand_field(32), 8'(rand_field(8)));
        else
            case ($urandom_range(0, 2))
                0:       load_sample(8'($urandom()), 3'($urandom()), 16'(rand_field(16)));
                1:       load_weight(8'($urandom()), 8'($urandom()), 8'(rand_field(8)));
                default: load_bias(8'($urandom()), rand_field(32), 8'(rand_field(8)));
            endcase
    endtask

    // Registers are changed only with the block idle: every expected result
    // collected, then a short pause for the last load to settle. The vector
    // register is written with random upper data bits, which it must ignore.
    task automatic quiesce_and_configure(input logic [8:0] elements,
                                         input logic [3:0] vectors);
        logic [8:0] vec_data;
        in_valid = 1'b0;
        while (affine_board.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
        vec_data  = {5'($urandom_range(0, 31)), vectors};
        cfg_we    = 1'b1;
        cfg_index = REG_ELEMENT_COUNT;
        cfg_data  = elements;
        affine_board.write_register(REG_ELEMENT_COUNT, elements);
        @(negedge clk);
        cfg_index = REG_VECTOR_COUNT;
        cfg_data  = vec_data;
        affine_board.write_register(REG_VECTOR_COUNT, vec_data);
        @(negedge clk);
        cfg_we        = 1'b0;
        stim_elements = elements;
        stim_vectors  = vectors;
        settings_made++;
    endtask

    task automatic run_phase(input logic [8:0] elements, input logic [3:0] vectors,
                             input int unsigned n_items);
        quiesce_and_configure(elements, vectors);
        repeat (n_items) random_transfer();
    endtask

    // Result side: the ready pattern switches between always ready, a coin
    // toss, rare acceptance and long regular stalls, each for a random span.
    initial
    begin : result_stall_pattern
        stall_mode_t mode;
        int unsigned span;
        int unsigned tick;
        out_ready = 1'b0;
        tick      = 0;
        forever
        begin
            mode = stall_mode_t'($urandom_range(0, 3));
            span = $urandom_range(20, 200);
            repeat (span)
            begin
                @(negedge clk);
                tick++;
                case (mode)
                    STALL_NONE:   out_ready = 1'b1;
                    STALL_COIN:   out_ready = 1'($urandom_range(0, 1));
                    STALL_SPARSE: out_ready = ($urandom_range(0, 5) == 0);
                    default:      out_ready = (tick % 24) < 3;
                endcase
            end
        end
    end

    // A result transfer is taken at the rising edge where valid meets ready.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            collected.row      = result_row;
            collected.lanes[0] = out_0;
            collected.lanes[1] = out_1;
            collected.lanes[2] = out_2;
            collected.lanes[3] = out_3;
            collected.lanes[4] = out_4;
            collected.lanes[5] = out_5;
            collected.lanes[6] = out_6;
            collected.lanes[7] = out_7;
            affine_board.check_result(collected);
        end
    end

    // Watchdog, far beyond the slowest run this stimulus can make.
    initial
    begin
        #(64'd12_000_000);
        $display("timeout with %0d results outstanding", affine_board.pending());
        $display("CHECK FAILED");
        $finish;
    end

    initial
    begin : stimulus
        logic [8:0]  el;
        logic [3:0]  vc;
        int unsigned sel;
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        op         = OP_LOAD_SAMPLE;
        column     = '0;
        vector     = '0;
        sample     = '0;
        row        = '0;
        weight     = '0;
        bias       = '0;
        multiplier = '0;
        cfg_we     = 1'b0;
        cfg_index  = REG_ELEMENT_COUNT;
        cfg_data   = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        repeat (2) @(negedge clk);

        // Directed part, at the reset setting of one element and one vector.
        // The most negative sample against the most negative weight, with the
        // most negative bias and the largest multiplier.
        load_sample(8'd0, 3'd0, 16'h8000);
        load_weight(8'd0, 8'd0, 8'h80);
        load_bias(8'd0, 32'h8000_0000, 8'hFF);
        compute_row(8'd0);
        // Largest positive values; a zero multiplier leaves only the bias.
        load_sample(8'd0, 3'd0, 16'h7FFF);
        load_weight(8'd255, 8'd0, 8'h7F);
        load_bias(8'd255, 32'h7FFF_FFFF, 8'h00);
        compute_row(8'd255);
        load_bias(8'd255, 32'h7FFF_FFFF, 8'hFF);
        compute_row(8'd255);
        // Top corners of the stores: last column and last vector, and row 128.
        load_sample(8'd255, 3'd7, 16'hFFFF);
        load_weight(8'd128, 8'd255, 8'hFF);
        load_bias(8'd128, 32'hFFFF_FFFF, 8'h01);
        compute_row(8'd128);
        // A zero weight, then mixed signs.
        load_weight(8'd0, 8'd0, 8'h00);
        compute_row(8'd0);
        load_weight(8'd0, 8'd0, 8'h7F);
        load_sample(8'd0, 3'd0, 16'h8000);
        compute_row(8'd0);
        load_weight(8'd0, 8'd0, 8'hFF);
        compute_row(8'd0);

        // Extreme settings first: no elements, all elements, counts beyond
        // the store that must saturate, no vectors and too many vectors.
        run_phase(9'd0,   4'd8,  30);
        run_phase(9'd256, 4'd1,  20);
        run_phase(9'd511, 4'd0,  15);
        run_phase(9'd16,  4'd15, 40);
        run_phase(9'd1,   4'd8,  30);
        run_phase(9'd7,   4'd0,  15);
        run_phase(9'd257, 4'd1,  10);

        // Then random settings, mostly small, now and then an extreme one.
        while (items_sent < TARGET_ITEMS)
        begin
            sel = $urandom_range(0, 19);
            if (sel == 0)
            begin
                el = 9'(256 + $urandom_range(0, 255));
                vc = 4'($urandom_range(0, 1));
            end
            else if (sel == 1)
            begin
                el = 9'd0;
                vc = 4'($urandom_range(0, 15));
            end
            else if (sel == 2)
            begin
                el = 9'($urandom_range(1, SMALL_ELEMENTS));
                vc = 4'($urandom_range(9, 15));
            end
            else if (sel == 3)
            begin
                el = 9'($urandom_range(1, SMALL_ELEMENTS));
                vc = 4'd0;
            end
            else if (sel == 4)
            begin
                el = 9'($urandom_range(SMALL_ELEMENTS + 1, 255));
                vc = 4'd1;
            end
            else
            begin
                el = 9'($urandom_range(1, SMALL_ELEMENTS));
                vc = 4'($urandom_range(1, 8));
            end
            run_phase(el, vc, $urandom_range(10, 60));
        end

        // Drain: every expected result, then a full compute's worth of cycles
        // in which any stray result would still be caught.
        in_valid = 1'b0;
        while (affine_board.pending() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("covered %0d input transfers and %0d checked results over %0d settings",
                 items_sent, affine_board.results_checked, settings_made);
        $display("settings included zero, full and saturating element and vector counts");
        if (affine_board.mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
